FILE: hw/rtl/fbpa_pkg.sv
// Shared types, constants and codes for the fixed block pool allocator.
// Depends on nothing; every other RTL file of the block but fbpa_ram uses it.
`default_nettype none

package fbpa_pkg;

  // Free stack geometry
  localparam int FREE_DEPTH = 1024;
  localparam int FREE_AW    = $clog2(FREE_DEPTH);
  localparam int FCNT_W     = $clog2(FREE_DEPTH + 1);

  // Page limit of the hardware, capped by the 8-bit page number
  localparam int PAGE_LIMIT = 256;
  localparam int PAGE_CAP   = (PAGE_LIMIT < 256) ? PAGE_LIMIT : 256;

  // Field widths
  localparam int PAGE_W  = 8;
  localparam int OFF_W   = 28;
  localparam int SIZE_W  = 16;
  localparam int CHUNK_W = 13;
  localparam int MAXPG_W = 9;

  // Clamp bounds of the configuration
  localparam int SIZE_MIN  = 8;
  localparam int CHUNK_MAX = 4096;

  // Reset values of the configuration registers
  localparam int SIZE_RST  = 8;
  localparam int CHUNK_RST = 512;
  localparam int MAXPG_RST = 256;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_BLK_SIZE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS_PER_PAGE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAGES       = 2'd2;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_ALLOCATED     = 2'd0,
    ST_OUT_OF_MEMORY = 2'd1,
    ST_FREED         = 2'd2,
    ST_OVERFLOW      = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [PAGE_W-1:0] free_page;
    logic [OFF_W-1:0]  free_offset;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic [PAGE_W-1:0] block_page;
    logic [OFF_W-1:0]  block_offset;
    logic              from_free_list;
  } out_t;

  // One free stack entry
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [OFF_W-1:0]  offset;
  } handle_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;     // capture the accepted item
    logic do_free;   // push the handle or flag overflow
    logic do_pop;    // pop: decrement count and read the stack top
    logic do_carve;  // carve a slot or open a page
    logic load_pop;  // load the popped handle into the result
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_free;
    logic stack_empty;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fbpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fbpa_dp.sv
// Datapath: configuration registers, free stack, page carving counters and
// result register. Depends on fbpa_pkg and fbpa_ram.
`default_nettype none

module fbpa_dp (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire fbpa_pkg::in_t                      in_data,
  input  wire logic                               cfg_we,
  input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fbpa_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire fbpa_pkg::ctrl_cmd_t                cmd,
  output      fbpa_pkg::dp_sts_t                  sts,
  output      fbpa_pkg::out_t                     out_data
);

  // Configuration
  logic [fbpa_pkg::SIZE_W-1:0]  blk_size;
  logic [fbpa_pkg::CHUNK_W-1:0] chunks_per_page;
  logic [fbpa_pkg::MAXPG_W-1:0] max_pages;

  // Latched item and allocator state
  fbpa_pkg::in_t                req;
  logic [fbpa_pkg::FCNT_W-1:0]  free_count;
  logic                         page_open;
  logic [fbpa_pkg::PAGE_W-1:0]  current_page;
  logic [fbpa_pkg::CHUNK_W-1:0] slots_used;
  logic [fbpa_pkg::OFF_W-1:0]   next_offset;
  fbpa_pkg::out_t               result;

  // Derived values
  logic [fbpa_pkg::SIZE_W-1:0]  eff_size;
  logic [fbpa_pkg::CHUNK_W-1:0] eff_chunks;
  logic [fbpa_pkg::MAXPG_W-1:0] pages_nz;
  logic [fbpa_pkg::MAXPG_W-1:0] eff_pages;
  logic [fbpa_pkg::MAXPG_W-1:0] new_page;
  logic                         can_carve;
  logic                         no_page;
  logic                         stack_full;
  logic [fbpa_pkg::FCNT_W-1:0]  top_index;
  logic                         ram_we;
  fbpa_pkg::handle_t            push_handle;
  fbpa_pkg::handle_t            pop_handle;

  // Clamp the configuration to its working range
  always_comb begin
    eff_size = (blk_size < fbpa_pkg::SIZE_W'(fbpa_pkg::SIZE_MIN))
             ? fbpa_pkg::SIZE_W'(fbpa_pkg::SIZE_MIN) : blk_size;
    if (chunks_per_page == '0) begin
      eff_chunks = fbpa_pkg::CHUNK_W'(1);
    end else if (chunks_per_page > fbpa_pkg::CHUNK_W'(fbpa_pkg::CHUNK_MAX)) begin
      eff_chunks = fbpa_pkg::CHUNK_W'(fbpa_pkg::CHUNK_MAX);
    end else begin
      eff_chunks = chunks_per_page;
    end
    pages_nz  = (max_pages == '0) ? fbpa_pkg::MAXPG_W'(1) : max_pages;
    eff_pages = (pages_nz > fbpa_pkg::MAXPG_W'(fbpa_pkg::PAGE_CAP))
              ? fbpa_pkg::MAXPG_W'(fbpa_pkg::PAGE_CAP) : pages_nz;
  end

  // Carve decisions
  assign can_carve  = page_open && (slots_used < eff_chunks);
  assign new_page   = page_open ? ({1'b0, current_page} + fbpa_pkg::MAXPG_W'(1)) : '0;
  assign no_page    = (new_page >= eff_pages);
  assign stack_full = (free_count >= fbpa_pkg::FCNT_W'(fbpa_pkg::FREE_DEPTH));
  assign top_index  = free_count - fbpa_pkg::FCNT_W'(1);

  assign ram_we               = cmd.do_free && !stack_full;
  assign push_handle.page     = req.free_page;
  assign push_handle.offset   = req.free_offset;

  fbpa_ram #(
    .WIDTH ($bits(fbpa_pkg::handle_t)),
    .DEPTH (fbpa_pkg::FREE_DEPTH)
  ) u_free_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_count[fbpa_pkg::FREE_AW-1:0]),
    .wdata (push_handle),
    .re    (cmd.do_pop),
    .raddr (top_index[fbpa_pkg::FREE_AW-1:0]),
    .rdata (pop_handle)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_size        <= fbpa_pkg::SIZE_W'(fbpa_pkg::SIZE_RST);
      chunks_per_page <= fbpa_pkg::CHUNK_W'(fbpa_pkg::CHUNK_RST);
      max_pages       <= fbpa_pkg::MAXPG_W'(fbpa_pkg::MAXPG_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        fbpa_pkg::CFG_BLK_SIZE:        blk_size        <= cfg_data;
        fbpa_pkg::CFG_CHUNKS_PER_PAGE: chunks_per_page <= cfg_data[fbpa_pkg::CHUNK_W-1:0];
        fbpa_pkg::CFG_MAX_PAGES:       max_pages       <= cfg_data[fbpa_pkg::MAXPG_W-1:0];
        default: ;
      endcase
    end
  end

  // Allocator state
  always_ff @(posedge clk) begin
    if (rst) begin
      free_count   <= '0;
      page_open    <= 1'b0;
      current_page <= '0;
      slots_used   <= '0;
      next_offset  <= '0;
    end else begin
      if (ram_we) begin
        free_count <= free_count + fbpa_pkg::FCNT_W'(1);
      end
      if (cmd.do_pop) begin
        free_count <= top_index;
      end
      if (cmd.do_carve) begin
        if (can_carve) begin
          slots_used  <= slots_used + fbpa_pkg::CHUNK_W'(1);
          next_offset <= next_offset + fbpa_pkg::OFF_W'(eff_size);
        end else if (!no_page) begin
          page_open    <= 1'b1;
          current_page <= new_page[fbpa_pkg::PAGE_W-1:0];
          slots_used   <= fbpa_pkg::CHUNK_W'(1);
          next_offset  <= fbpa_pkg::OFF_W'(eff_size);
        end
      end
    end
  end

  // Latched item and result register (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req <= in_data;
    end
    if (cmd.do_free) begin
      result.status         <= stack_full ? fbpa_pkg::ST_OVERFLOW : fbpa_pkg::ST_FREED;
      result.block_page     <= '0;
      result.block_offset   <= '0;
      result.from_free_list <= 1'b0;
    end
    if (cmd.do_carve) begin
      result.from_free_list <= 1'b0;
      if (can_carve) begin
        result.status       <= fbpa_pkg::ST_ALLOCATED;
        result.block_page   <= current_page;
        result.block_offset <= next_offset;
      end else if (no_page) begin
        result.status       <= fbpa_pkg::ST_OUT_OF_MEMORY;
        result.block_page   <= '0;
        result.block_offset <= '0;
      end else begin
        result.status       <= fbpa_pkg::ST_ALLOCATED;
        result.block_page   <= new_page[fbpa_pkg::PAGE_W-1:0];
        result.block_offset <= '0;
      end
    end
    if (cmd.load_pop) begin
      result.status         <= fbpa_pkg::ST_ALLOCATED;
      result.block_page     <= pop_handle.page;
      result.block_offset   <= pop_handle.offset;
      result.from_free_list <= 1'b1;
    end
  end

  assign sts.is_free     = (req.cmd == fbpa_pkg::CMD_FREE);
  assign sts.stack_empty = (free_count == '0);
  assign out_data        = result;

`ifndef SYNTHESIS
  // Stack count never passes the stack depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= fbpa_pkg::FCNT_W'(fbpa_pkg::FREE_DEPTH))
    else $error("free stack count above depth");

  // A pop is only issued on a non-empty stack, and it lowers the count
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.do_pop |-> (free_count != '0) ##1 (free_count == $past(free_count) - 1'b1))
    else $error("pop from empty free stack");

  // Without an open page no slot has been carved
  a_closed_page: assert property (@(posedge clk) disable iff (rst)
    !page_open |-> (slots_used == '0) && (next_offset == '0))
    else $error("slot counters moved with no page open");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/fbpa_ctrl.sv
// Controller: sequences accept, execute, stack read and result hand-off.
// Depends on fbpa_pkg.
`default_nettype none

module fbpa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_ready,
  output      logic                out_valid,
  input  wire logic                out_ready,
  input  wire fbpa_pkg::dp_sts_t   sts,
  output      fbpa_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RDOUT
  } state_t;

  state_t state;
  logic   out_free;

  // Result slot can take a new item this cycle
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // Commands to the datapath
  always_comb begin
    cmd          = '0;
    cmd.latch    = in_valid && (state == S_IDLE);
    cmd.load_pop = (state == S_RDOUT);
    if (state == S_EXEC && out_free) begin
      if (sts.is_free) begin
        cmd.do_free = 1'b1;
      end else if (!sts.stack_empty) begin
        cmd.do_pop = 1'b1;
      end else begin
        cmd.do_carve = 1'b1;
      end
    end
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd.do_pop) begin
            state <= S_RDOUT;
          end else if (cmd.do_free || cmd.do_carve) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
          end
        end
        S_RDOUT: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fixed_block_pool_allocator_core.sv
// Top level of the fixed block pool allocator: controller plus datapath.
// Depends on fbpa_pkg, fbpa_ctrl, fbpa_dp (and fbpa_ram below it).
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------
//   in      | in_valid / in_ready  | in_data  (cmd, free_page, free_offset)
//   out     | out_valid / out_ready| out_data (status, block_page,
//           |                      |           block_offset, from_free_list)
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Free, fresh carve and out_of_memory items pass from accept through the
// execute state to the result; a recycled block adds a read state for the
// registered read port of the free stack RAM. One item is in flight at a time.
// A new item is accepted while the previous result waits on out_ready;
// execution holds until the result register is free.
// Synchronous reset clears counters and config; the stack RAM needs no clear.
// cfg_ready is always high.
`default_nettype none

module fixed_block_pool_allocator_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire fbpa_pkg::in_t                   in_data,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      fbpa_pkg::out_t                  out_data,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data
);

  fbpa_pkg::ctrl_cmd_t cmd;
  fbpa_pkg::dp_sts_t   sts;

  assign cfg_ready = 1'b1;

  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fbpa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
